FILE: design/brace_balanced_frame_receiver_macros.svh
// Assertion macros shared by the frame receiver modules
`ifndef BRACE_BALANCED_FRAME_RECEIVER_MACROS_SVH
`define BRACE_BALANCED_FRAME_RECEIVER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset
`define BBFR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bbfr assertion failed");
// Next-cycle implication, disabled in reset
`define BBFR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bbfr assertion failed");
`else
`define BBFR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BBFR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/bbfr_pkg.sv
// Types and constants of the brace-balanced frame receiver
package bbfr_pkg;

  localparam int IDX_W    = 9;
  localparam int LIM_B_W  = 8;
  localparam int LEN_W    = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 9;

  // Item operation codes
  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BRACE_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_LIMIT = 2'd1;

  localparam logic [LIM_B_W-1:0] BRACE_LIMIT_RST  = 8'd20;
  localparam logic [LEN_W-1:0]   LENGTH_LIMIT_RST = 9'd256;

  localparam logic [7:0] OPEN_BRACE  = 8'h7B;
  localparam logic [7:0] CLOSE_BRACE = 8'h7D;

  typedef struct packed {
    logic [1:0]       op;
    logic [7:0]       rx_byte;
    logic [IDX_W-1:0] read_index;
  } in_t;

  typedef struct packed {
    logic             byte_stored;
    logic             frame_done;
    logic [LEN_W-1:0] frame_length;
    logic             frame_dropped;
    logic [7:0]       read_data;
  } out_t;

  // Status of one item, as the control logic reports it
  typedef struct packed {
    logic             byte_stored;
    logic             frame_done;
    logic [LEN_W-1:0] frame_length;
    logic             frame_dropped;
  } stat_t;

  // Buffer write request
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } wr_req_t;

endpackage

FILE: design/bbfr_store.sv
// Frame buffer: synchronous memory, one write and one registered read port
module bbfr_store
  import bbfr_pkg::*;
#(
  parameter int BUF_DEPTH = 512
) (
  input  logic             clk,
  input  wr_req_t          wr_req,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [7:0]       rd_data
);

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int IDX_MAX = (1 << IDX_W) - 1;

  logic [7:0]    mem [BUF_DEPTH];
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  // Index modulo depth by up to six conditional subtractions of shifted depth (exact below 64 * BUF_DEPTH)
  function automatic logic [AW-1:0] wrap_idx(input logic [IDX_W-1:0] v);
    logic [IDX_W-1:0] r;
    r = v;
    for (int k = 5; k >= 0; k--) begin
      if ((BUF_DEPTH << k) <= IDX_MAX) begin
        if (32'(r) >= (BUF_DEPTH << k)) begin
          r = r - IDX_W'(BUF_DEPTH << k);
        end
      end
    end
    return AW'(r);
  endfunction

  assign wr_addr = wrap_idx(wr_req.idx);
  assign rd_addr = wrap_idx(rd_idx);

  // Write port
  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      mem[wr_addr] <= wr_req.data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/bbfr_ctrl.sv
// Frame capture control: brace counts, length, done and capture flags
`include "brace_balanced_frame_receiver_macros.svh"
module bbfr_ctrl
  import bbfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_acc,
  input  in_t                item,
  input  logic [LIM_B_W-1:0] brace_limit,
  input  logic [LEN_W-1:0]   length_limit,
  output wr_req_t            wr_req,
  output stat_t              stat
);

  logic [LEN_W-1:0]   stored_length_r, stored_length_nxt;
  logic               done_r, done_nxt;
  logic               capturing_r, capturing_nxt;
  logic [LIM_B_W-1:0] open_count_r, open_count_nxt;
  logic [LIM_B_W-1:0] close_count_r, close_count_nxt;

  logic             is_open, is_close, idle, cap;
  logic [LIM_B_W:0] op_sum, cl_sum, op_fin, cl_fin;
  logic [LEN_W:0]   len_sum;
  logic             balanced, over;

  // Candidate counts and limit check for a stored byte
  assign is_open  = (item.rx_byte == OPEN_BRACE);
  assign is_close = (item.rx_byte == CLOSE_BRACE);
  assign idle     = (stored_length_r == '0) && !done_r;
  assign cap      = idle ? is_open : capturing_r;
  assign op_sum   = {1'b0, open_count_r} + (LIM_B_W+1)'(is_open);
  assign cl_sum   = {1'b0, close_count_r} + (LIM_B_W+1)'(is_close);
  assign balanced = (op_sum == cl_sum);
  assign op_fin   = balanced ? '0 : op_sum;
  assign cl_fin   = balanced ? '0 : cl_sum;
  assign len_sum  = {1'b0, stored_length_r} + (LEN_W+1)'(1);
  assign over     = (op_fin > {1'b0, brace_limit}) || (cl_fin > {1'b0, brace_limit}) ||
                    (len_sum > {1'b0, length_limit});

  // Next state per item
  always_comb begin
    stored_length_nxt  = stored_length_r;
    done_nxt           = done_r;
    capturing_nxt      = capturing_r;
    open_count_nxt     = open_count_r;
    close_count_nxt    = close_count_r;
    wr_req.en          = 1'b0;
    wr_req.idx         = stored_length_r;
    wr_req.data        = item.rx_byte;
    stat.byte_stored   = 1'b0;
    stat.frame_dropped = 1'b0;
    if (item_acc) begin
      case (item.op)
        OP_BYTE: begin
          capturing_nxt = cap;
          if (!cap) begin
            stored_length_nxt = '0;
            done_nxt          = 1'b0;
          end else if (!done_r) begin
            wr_req.en        = 1'b1;
            stat.byte_stored = 1'b1;
            if (over) begin
              stored_length_nxt  = '0;
              done_nxt           = 1'b0;
              open_count_nxt     = '0;
              close_count_nxt    = '0;
              stat.frame_dropped = 1'b1;
            end else begin
              stored_length_nxt = len_sum[LEN_W-1:0];
              done_nxt          = balanced;
              open_count_nxt    = op_fin[LIM_B_W-1:0];
              close_count_nxt   = cl_fin[LIM_B_W-1:0];
            end
          end
        end
        OP_RELEASE: begin
          stored_length_nxt = '0;
          done_nxt          = 1'b0;
        end
        default: begin
        end
      endcase
    end
    stat.frame_done   = done_nxt;
    stat.frame_length = stored_length_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_length_r <= '0;
      done_r          <= 1'b0;
      capturing_r     <= 1'b0;
      open_count_r    <= '0;
      close_count_r   <= '0;
    end else begin
      stored_length_r <= stored_length_nxt;
      done_r          <= done_nxt;
      capturing_r     <= capturing_nxt;
      open_count_r    <= open_count_nxt;
      close_count_r   <= close_count_nxt;
    end
  end

  // A finished frame always holds bytes and leaves the counts cleared
  `BBFR_ASSERT_IMP(a_done_len, clk, rst_n, done_r, stored_length_r != '0)
  `BBFR_ASSERT_IMP(a_done_cnt, clk, rst_n, done_r, open_count_r == '0 && close_count_r == '0)
  // No buffer write once the frame is done
  `BBFR_ASSERT_IMP(a_no_wr_done, clk, rst_n, wr_req.en, !done_r)
  // A discard only happens on a byte that was stored
  `BBFR_ASSERT_IMP(a_drop_stored, clk, rst_n, stat.frame_dropped, stat.byte_stored)

endmodule

FILE: design/brace_balanced_frame_receiver.sv
// An accepted word goes through the result stage into the output register, which
// raises out_valid. Throughput: one word per cycle while out is not stalled; the
// buffer read, registered on accept, joins the status in the output register.
// With out stalled, one more word enters the result stage, then in_stall rises.
// Reset clears control state and sets brace_limit 20, length_limit 256;
// buffer contents stay undefined until written, with no clearing pass.
`include "brace_balanced_frame_receiver_macros.svh"
module brace_balanced_frame_receiver
  import bbfr_pkg::*;
#(
  parameter int BUF_DEPTH = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic               in_acc, out_acc, s1_adv, rd_en;
  logic [LIM_B_W-1:0] brace_limit_r;
  logic [LEN_W-1:0]   length_limit_r;
  logic               s1_v_r, s1_rd_r;
  stat_t              s1_stat_r;
  logic               out_v_r;
  out_t               out_data_r;
  wr_req_t            wr_req;
  stat_t              stat;
  logic [7:0]         rd_data;

  // Handshakes
  assign s1_adv    = !out_v_r || !out_stall;
  assign in_stall  = s1_v_r && !s1_adv;
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_v_r && !out_stall;
  assign out_valid = out_v_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;
  assign rd_en     = in_acc && (in_data.op == OP_READ);

  bbfr_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_acc     (in_acc),
    .item         (in_data),
    .brace_limit  (brace_limit_r),
    .length_limit (length_limit_r),
    .wr_req       (wr_req),
    .stat         (stat)
  );

  bbfr_store #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_req  (wr_req),
    .rd_en   (rd_en),
    .rd_idx  (in_data.read_index),
    .rd_data (rd_data)
  );

  // Control: limits and stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brace_limit_r  <= BRACE_LIMIT_RST;
      length_limit_r <= LENGTH_LIMIT_RST;
      s1_v_r         <= 1'b0;
      out_v_r        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BRACE_LIMIT:  brace_limit_r  <= cfg_data[LIM_B_W-1:0];
          CFG_LENGTH_LIMIT: length_limit_r <= cfg_data[LEN_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_v_r && s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_acc) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload: result stage waits for the memory read, then the output word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_stat_r <= stat;
      s1_rd_r   <= (in_data.op == OP_READ);
    end
    if (s1_v_r && s1_adv) begin
      out_data_r.byte_stored   <= s1_stat_r.byte_stored;
      out_data_r.frame_done    <= s1_stat_r.frame_done;
      out_data_r.frame_length  <= s1_stat_r.frame_length;
      out_data_r.frame_dropped <= s1_stat_r.frame_dropped;
      out_data_r.read_data     <= s1_rd_r ? rd_data : 8'd0;
    end
  end

  // Input is only taken when the result stage is free or moving on
  `BBFR_ASSERT_IMP(a_acc_room, clk, rst_n, in_acc, !s1_v_r || s1_adv)
  // A held read in the result stage keeps its read word
  `BBFR_ASSERT_NXT(a_rd_hold, clk, rst_n, s1_v_r && s1_rd_r && !s1_adv, $stable(rd_data))
  // Stalling the input means a result is parked in the result stage
  `BBFR_ASSERT_IMP(a_stall_full, clk, rst_n, in_stall, s1_v_r && out_v_r)

endmodule
